// ===== rtl/byte_pipe_fifo_controller_unit_macros.svh =====
// Assertion macros shared by the byte pipe RTL.
`ifndef BYTE_PIPE_FIFO_CONTROLLER_UNIT_MACROS_SVH
`define BYTE_PIPE_FIFO_CONTROLLER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPFC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BPFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bpfc_pkg.sv =====
// Shared types and constants of the byte pipe.
`default_nettype none
package bpfc_pkg;

  // Ring store geometry and open count limits.
  localparam int unsigned DEPTH    = 65536;
  localparam int unsigned ADDR_W   = $clog2(DEPTH);
  localparam int unsigned FILL_W   = ADDR_W + 1;
  localparam int unsigned MAX_REFS = 255;
  localparam int unsigned REF_W    = $clog2(MAX_REFS + 1);

  // Operation codes carried by the input transfer.
  typedef enum logic [2:0] {
    MODE_WRITE    = 3'd0,
    MODE_READ     = 3'd1,
    MODE_OPEN_RD  = 3'd2,
    MODE_OPEN_WR  = 3'd3,
    MODE_CLOSE_RD = 3'd4,
    MODE_CLOSE_WR = 3'd5
  } mode_t;

  // Status codes carried by the result transfer.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BLOCK = 2'd1,
    ST_EOF   = 2'd2,
    ST_PIPE  = 2'd3
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/bpfc_ram.sv =====
// Simple dual-port synchronous RAM with a registered read.
`default_nettype none
module bpfc_ram #(
  parameter int unsigned ADDR_W = 16,
  parameter int unsigned DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [(1 << ADDR_W)];
  logic [DATA_W-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== rtl/byte_pipe_fifo_controller_unit.sv =====
// Top level of the byte pipe: control registers, ring store and result register.
`default_nettype none
// The block takes one operation per cycle unless a stalled result blocks the input,
// returns one result per operation in the cycle after the transfer, through a single
// result register; input is accepted when it is empty or emptied in the same cycle.
// Pointers, fill level, full latch and open counts live in flip-flops and are
// updated at the input transfer; the bytes live in a 64 KiB ring store with one
// write and one read port, and a read's byte appears from the store's registered
// output in the result cycle. The store needs no clearing after reset, so the
// block is ready straight away. Capacity may only be written while the pipe is idle.
module byte_pipe_fifo_controller_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // Configuration: capacity in bytes.
  input  wire logic                        cfg_wr_en,
  input  wire logic [bpfc_pkg::FILL_W-1:0] cfg_wr_data,
  // Input stream.
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [7:0]                  in_tdata,   // [7:0] data_byte
  input  wire logic [2:0]                  in_tuser,   // [2:0] mode
  // Result stream.
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // [7:0] data_out, [24:8] fill_count, [25] read_ready, [26] read_hangup,
  // [27] write_ready, [28] write_error, [31:29] zero
  output logic [31:0]                      out_tdata,
  output logic [1:0]                       out_tuser   // [1:0] status
);

  import bpfc_pkg::*;

  `include "byte_pipe_fifo_controller_unit_macros.svh"

  // Pipe state.
  logic [FILL_W-1:0] cap_r;
  logic [ADDR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [ADDR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              full_latch_r, full_latch_nxt;
  logic [REF_W-1:0]  rd_refs_r, rd_refs_nxt;
  logic [REF_W-1:0]  wr_refs_r, wr_refs_nxt;

  // Result register.
  logic              out_valid_r;
  status_t           out_status_r, status_nxt;
  logic              out_rd_ok_r;
  logic [FILL_W-1:0] out_fill_r;
  logic              out_rd_ready_r, out_hangup_r, out_wr_ready_r, out_wr_error_r;

  logic              in_xfer;
  logic              ram_wr_en, ram_rd_en;
  logic [7:0]        ram_rd_data;
  logic [FILL_W-1:0] wr_inc, rd_inc, cap_eff;
  mode_t             mode;

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;
  assign mode      = mode_t'(in_tuser);

  // Pointer advance with wrap at the capacity in use.
  assign wr_inc = {1'b0, wr_ptr_r} + FILL_W'(1);
  assign rd_inc = {1'b0, rd_ptr_r} + FILL_W'(1);

  // Operation decode and next state.
  always_comb begin
    rd_ptr_nxt     = rd_ptr_r;
    wr_ptr_nxt     = wr_ptr_r;
    fill_nxt       = fill_r;
    full_latch_nxt = full_latch_r;
    rd_refs_nxt    = rd_refs_r;
    wr_refs_nxt    = wr_refs_r;
    status_nxt     = ST_OK;
    ram_wr_en      = 1'b0;
    ram_rd_en      = 1'b0;
    case (mode)
      MODE_WRITE: begin
        if (rd_refs_r == '0) begin
          status_nxt = ST_PIPE;
        end else if (fill_r >= cap_r) begin
          status_nxt = ST_BLOCK;
        end else begin
          ram_wr_en  = in_xfer;
          wr_ptr_nxt = (wr_inc >= cap_r) ? '0 : wr_inc[ADDR_W-1:0];
          fill_nxt   = fill_r + FILL_W'(1);
          if (fill_nxt >= cap_r) begin
            full_latch_nxt = 1'b1;
          end
        end
      end
      MODE_READ: begin
        if (fill_r == '0) begin
          status_nxt = (wr_refs_r != '0) ? ST_BLOCK : ST_EOF;
        end else begin
          ram_rd_en  = in_xfer;
          rd_ptr_nxt = (rd_inc >= cap_r) ? '0 : rd_inc[ADDR_W-1:0];
          fill_nxt   = fill_r - FILL_W'(1);
          if (fill_nxt == '0) begin
            full_latch_nxt = 1'b0;
          end
        end
      end
      MODE_OPEN_RD: begin
        if (rd_refs_r < REF_W'(MAX_REFS)) rd_refs_nxt = rd_refs_r + REF_W'(1);
      end
      MODE_OPEN_WR: begin
        if (wr_refs_r < REF_W'(MAX_REFS)) wr_refs_nxt = wr_refs_r + REF_W'(1);
      end
      MODE_CLOSE_RD: begin
        if (rd_refs_r != '0) rd_refs_nxt = rd_refs_r - REF_W'(1);
      end
      MODE_CLOSE_WR: begin
        if (wr_refs_r != '0) wr_refs_nxt = wr_refs_r - REF_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Out-of-range capacities are folded into the legal range when written.
  always_comb begin
    if (cfg_wr_data == '0) begin
      cap_eff = FILL_W'(1);
    end else if (cfg_wr_data > FILL_W'(DEPTH)) begin
      cap_eff = FILL_W'(DEPTH);
    end else begin
      cap_eff = cfg_wr_data;
    end
  end

  // Control state and capacity register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r        <= FILL_W'(DEPTH);
      rd_ptr_r     <= '0;
      wr_ptr_r     <= '0;
      fill_r       <= '0;
      full_latch_r <= 1'b0;
      rd_refs_r    <= REF_W'(1);
      wr_refs_r    <= REF_W'(1);
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cap_eff;
      end
      if (in_xfer) begin
        rd_ptr_r     <= rd_ptr_nxt;
        wr_ptr_r     <= wr_ptr_nxt;
        fill_r       <= fill_nxt;
        full_latch_r <= full_latch_nxt;
        rd_refs_r    <= rd_refs_nxt;
        wr_refs_r    <= wr_refs_nxt;
      end
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload, taken from the state after the operation.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_status_r   <= status_nxt;
      out_rd_ok_r    <= ram_rd_en;
      out_fill_r     <= fill_nxt;
      out_rd_ready_r <= (fill_nxt != '0) || (wr_refs_nxt == '0);
      out_hangup_r   <= (wr_refs_nxt == '0);
      out_wr_ready_r <= (fill_nxt < cap_r) && !full_latch_nxt;
      out_wr_error_r <= (rd_refs_nxt == '0);
    end
  end

  // Ring store.
  bpfc_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (8)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (wr_ptr_r),
    .wr_data (in_tdata),
    .rd_en   (ram_rd_en),
    .rd_addr (rd_ptr_r),
    .rd_data (ram_rd_data)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {3'b000, out_wr_error_r, out_wr_ready_r, out_hangup_r, out_rd_ready_r,
                       out_fill_r, (out_rd_ok_r ? ram_rd_data : 8'h00)};

  // The full latch is only ever set while bytes are held.
  `BPFC_ASSERT_SAME(a_latch_holds_data, clk, rst_n, full_latch_r, fill_r != '0,
    "full latch set with an empty ring")
  // A successful write adds exactly one byte.
  `BPFC_ASSERT_NEXT(a_write_adds_one, clk, rst_n, in_xfer && ram_wr_en,
    fill_r == $past(fill_r) + FILL_W'(1), "fill level wrong after a write")
  // A successful read removes exactly one byte.
  `BPFC_ASSERT_NEXT(a_read_takes_one, clk, rst_n, in_xfer && ram_rd_en,
    fill_r == $past(fill_r) - FILL_W'(1), "fill level wrong after a read")
  // A stalled result blocks the input so the store output is not overwritten.
  `BPFC_ASSERT_SAME(a_stall_blocks_input, clk, rst_n, out_valid_r && !out_tready, !in_tready,
    "input accepted while a result is stalled")

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the byte pipe: directed and random operations checked against a predictor.
module tb;
  import bpfc_pkg::*;

  // Codes outside the operation set, which the pipe must ignore.
  localparam logic [2:0] MODE_NOP_6 = 3'd6;
  localparam logic [2:0] MODE_NOP_7 = 3'd7;

  localparam int unsigned REPORT_LIMIT = 20;
  localparam int unsigned LONG_HOLD    = 150;
  localparam int unsigned DRAIN_LIMIT  = 5000;

  // One expected result, in the order of the fields on the result stream.
  typedef struct packed {
    logic              write_error;
    logic              write_ready;
    logic              read_hangup;
    logic              read_ready;
    logic [FILL_W-1:0] fill_count;
    logic [7:0]        data_out;
    status_t           status;
  } pipe_result_t;

  // Operation mixes used by the random phases.
  typedef enum {
    MIX_BALANCED,
    MIX_FILL,
    MIX_DRAIN,
    MIX_ENDS,
    MIX_OPEN_RD,
    MIX_OPEN_WR
  } op_mix_t;

  // Pipe predictor: its own ring, pointers, fill level and open counts, and the queue of
  // results still to come from the block.
  class pipe_scoreboard;
    logic [7:0]   ring_bytes [DEPTH];
    bit           ring_written [DEPTH];
    int unsigned  rd_ptr;
    int unsigned  wr_ptr;
    int unsigned  fill_level;
    bit           full_latch;
    int unsigned  reader_refs;
    int unsigned  writer_refs;
    int unsigned  capacity;
    pipe_result_t expected_q [$];
    int unsigned  errors;

    function new();
      rd_ptr      = 0;
      wr_ptr      = 0;
      fill_level  = 0;
      full_latch  = 1'b0;
      reader_refs = 1;
      writer_refs = 1;
      capacity    = DEPTH;
      errors      = 0;
    endfunction

    // Capacity in force: zero acts as one, anything above the store depth as the depth.
    function int unsigned ring_size();
      if (capacity == 0) return 1;
      if (capacity > DEPTH) return DEPTH;
      return capacity;
    endfunction

    function int unsigned wrap_next(int unsigned p);
      int unsigned n;
      n = p + 1;
      return (n >= ring_size()) ? 0 : n;
    endfunction

    function int unsigned slot_of(int unsigned p);
      return (p < DEPTH) ? p : 0;
    endfunction

    // True when a read now would fetch a store entry that was never written.
    function bit read_hits_unwritten();
      return fill_level != 0 && !ring_written[slot_of(rd_ptr)];
    endfunction

    function void set_capacity(int unsigned value);
      capacity = value & 32'h1FFFF;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Apply one accepted operation and queue the result it must produce.
    function void note_op(logic [2:0] mode, logic [7:0] data_byte);
      int unsigned  size;
      pipe_result_t res;
      size       = ring_size();
      res        = '0;
      res.status = ST_OK;
      case (mode)
        MODE_WRITE: begin
          if (reader_refs == 0) begin
            res.status = ST_PIPE;
          end else if (fill_level >= size) begin
            res.status = ST_BLOCK;
          end else begin
            ring_bytes[slot_of(wr_ptr)]   = data_byte;
            ring_written[slot_of(wr_ptr)] = 1'b1;
            wr_ptr = wrap_next(wr_ptr);
            fill_level++;
            if (fill_level >= size) full_latch = 1'b1;
          end
        end
        MODE_READ: begin
          if (fill_level == 0) begin
            res.status = (writer_refs != 0) ? ST_BLOCK : ST_EOF;
          end else begin
            res.data_out = ring_bytes[slot_of(rd_ptr)];
            rd_ptr = wrap_next(rd_ptr);
            fill_level--;
            if (fill_level == 0) full_latch = 1'b0;
          end
        end
        MODE_OPEN_RD: if (reader_refs < MAX_REFS) reader_refs++;
        MODE_OPEN_WR: if (writer_refs < MAX_REFS) writer_refs++;
        MODE_CLOSE_RD: if (reader_refs > 0) reader_refs--;
        MODE_CLOSE_WR: if (writer_refs > 0) writer_refs--;
        default: ;
      endcase
      res.fill_count  = FILL_W'(fill_level);
      res.read_ready  = fill_level > 0 || writer_refs == 0;
      res.read_hangup = writer_refs == 0;
      res.write_ready = fill_level < size && !full_latch;
      res.write_error = reader_refs == 0;
      expected_q.push_back(res);
    endfunction

    task report(string what);
      errors++;
      if (errors <= REPORT_LIMIT) $display("%0t: mismatch: %s", $time, what);
    endtask

    // Compare one result transfer with the oldest expectation, field by field.
    task check_result(logic [31:0] tdata, logic [1:0] tuser);
      pipe_result_t exp;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing expected, data %h status %0d", tdata, tuser));
        return;
      end
      exp = expected_q.pop_front();
      if (tuser !== exp.status)
        report($sformatf("status %0d, expected %0d", tuser, exp.status));
      if (tdata[7:0] !== exp.data_out)
        report($sformatf("data_out %h, expected %h", tdata[7:0], exp.data_out));
      if (tdata[24:8] !== exp.fill_count)
        report($sformatf("fill_count %0d, expected %0d", tdata[24:8], exp.fill_count));
      if (tdata[25] !== exp.read_ready)
        report($sformatf("read_ready %b, expected %b", tdata[25], exp.read_ready));
      if (tdata[26] !== exp.read_hangup)
        report($sformatf("read_hangup %b, expected %b", tdata[26], exp.read_hangup));
      if (tdata[27] !== exp.write_ready)
        report($sformatf("write_ready %b, expected %b", tdata[27], exp.write_ready));
      if (tdata[28] !== exp.write_error)
        report($sformatf("write_error %b, expected %b", tdata[28], exp.write_error));
      if (tdata[31:29] !== 3'b000)
        report($sformatf("padding bits %b, expected zero", tdata[31:29]));
    endtask
  endclass

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              cfg_wr_en   = 1'b0;
  logic [FILL_W-1:0] cfg_wr_data = '0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata    = '0;
  logic [2:0]        in_tuser    = '0;
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [31:0]       out_tdata;
  logic [1:0]        out_tuser;

  pipe_scoreboard pipe_sb = new();
  bit             steady_flow  = 1'b0;
  bit             hold_request = 1'b0;

  byte_pipe_fifo_controller_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Idle length: mostly none, sometimes short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  // Weighted choice of operation code; the table is ordered by code value.
  function automatic logic [2:0] pick_mode(op_mix_t mix);
    int unsigned w [8];
    int unsigned total;
    int unsigned r;
    case (mix)
      MIX_BALANCED: w = '{40, 40, 3, 3, 5, 5, 2, 2};
      MIX_FILL:     w = '{65, 25, 2, 2, 2, 2, 1, 1};
      MIX_DRAIN:    w = '{25, 65, 2, 2, 2, 2, 1, 1};
      MIX_ENDS:     w = '{25, 25, 10, 10, 14, 14, 1, 1};
      MIX_OPEN_RD:  w = '{1, 1, 98, 0, 0, 0, 0, 0};
      default:      w = '{1, 1, 0, 98, 0, 0, 0, 0};
    endcase
    total = 0;
    foreach (w[i]) total += w[i];
    r = $urandom_range(0, total - 1);
    for (int i = 0; i < 8; i++) begin
      if (r < w[i]) return 3'(i);
      r -= w[i];
    end
    return MODE_NOP_7;
  endfunction

  // Offer one operation, hold it until the transfer, then perhaps leave a gap.
  task automatic send_op(logic [2:0] mode, logic [7:0] data_byte);
    int unsigned gap;
    // A read that would reach a never-written store entry is swapped for an ignored code.
    if (mode == MODE_READ && pipe_sb.read_hits_unwritten()) mode = MODE_NOP_7;
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= data_byte;
    do @(posedge clk); while (!in_tready);
    pipe_sb.note_op(mode, data_byte);
    gap = steady_flow ? 0 : pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Write the capacity once every result is back and the pipe has settled.
  task automatic write_capacity(int unsigned value);
    in_tvalid <= 1'b0;
    while (pipe_sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= FILL_W'(value);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    pipe_sb.set_capacity(value);
  endtask

  task automatic run_phase(int unsigned count, int unsigned cap_value, op_mix_t mix,
                           bit steady, bit with_hold);
    write_capacity(cap_value);
    steady_flow = steady;
    if (with_hold) hold_request = 1'b1;
    repeat (count) send_op(pick_mode(mix), 8'($urandom_range(0, 255)));
  endtask

  // Result side: random stalls, steady stretches and the long hold-off; every result
  // transfer goes to the scoreboard.
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned gap;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) pipe_sb.check_result(out_tdata, out_tuser);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (steady_flow) begin
        stall_left = 0;
        out_tready <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        gap = pick_gap();
        if (gap != 0) stall_left = gap - 1;
        out_tready <= (gap == 0);
      end
    end
  end

  // Main sequence: reset, directed operations, random phases, drain and verdict.
  initial begin
    int unsigned waited;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Empty pipe read, ignored codes, then a few bytes at the reset capacity.
    send_op(MODE_READ, 8'h00);
    send_op(MODE_NOP_6, 8'hFF);
    send_op(MODE_NOP_7, 8'h00);
    send_op(MODE_WRITE, 8'h00);
    send_op(MODE_WRITE, 8'hFF);
    send_op(MODE_WRITE, 8'hA5);

    // Shrink the ring below the bytes held: writes block until reads bring the fill down.
    write_capacity(2);
    send_op(MODE_WRITE, 8'h5A);
    send_op(MODE_READ, 8'h00);
    send_op(MODE_READ, 8'h00);
    send_op(MODE_READ, 8'h00);

    // Fill to capacity, block, and see the write-ready flag stay off until fully drained.
    send_op(MODE_WRITE, 8'h01);
    send_op(MODE_WRITE, 8'h02);
    send_op(MODE_WRITE, 8'h03);
    send_op(MODE_READ, 8'h00);
    send_op(MODE_WRITE, 8'h04);
    send_op(MODE_READ, 8'h00);
    send_op(MODE_READ, 8'h00);

    // Write end closed past zero: writes still go through, an empty read gives end of file.
    send_op(MODE_CLOSE_WR, 8'h00);
    send_op(MODE_CLOSE_WR, 8'h00);
    send_op(MODE_WRITE, 8'h77);
    send_op(MODE_READ, 8'h00);
    send_op(MODE_READ, 8'h00);
    send_op(MODE_OPEN_WR, 8'h00);

    // Read end closed: a write is a broken pipe, and a read of the empty ring blocks.
    send_op(MODE_CLOSE_RD, 8'h00);
    send_op(MODE_WRITE, 8'hC3);
    send_op(MODE_READ, 8'h00);
    send_op(MODE_OPEN_RD, 8'h00);

    // Random phases over several capacities, the extremes among them.
    run_phase(10, 3, MIX_BALANCED, 1'b0, 1'b0);
    run_phase(10, 1, MIX_FILL, 1'b0, 1'b0);
    run_phase(10, 0, MIX_BALANCED, 1'b1, 1'b0);
    run_phase(16, 5, MIX_FILL, 1'b1, 1'b1);
    run_phase(10, 6, MIX_ENDS, 1'b0, 1'b0);
    run_phase(10, 131071, MIX_FILL, 1'b0, 1'b0);
    run_phase(10, 16, MIX_DRAIN, 1'b0, 1'b0);
    run_phase(10, 2, MIX_ENDS, 1'b1, 1'b0);
    run_phase(10, 65536, MIX_BALANCED, 1'b0, 1'b0);
    // Drive each open count into saturation.
    run_phase(270, 4, MIX_OPEN_RD, 1'b0, 1'b0);
    run_phase(270, 7, MIX_OPEN_WR, 1'b0, 1'b0);

    in_tvalid   <= 1'b0;
    steady_flow = 1'b1;
    waited      = 0;
    while (pipe_sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (5) @(posedge clk);
    if (pipe_sb.pending() != 0)
      pipe_sb.report($sformatf("%0d results never arrived", pipe_sb.pending()));

    if (pipe_sb.errors == 0) begin
      $display("** byte_pipe_fifo_controller_unit: PASSED **");
    end else begin
      $display("** byte_pipe_fifo_controller_unit: FAILED **");
    end
    $finish;
  end

  // Guard against a hung run.
  initial begin
    #2000000;
    $display("** byte_pipe_fifo_controller_unit: FAILED **");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/bpfc_pkg.sv
rtl/bpfc_ram.sv
rtl/byte_pipe_fifo_controller_unit.sv
tb/tb.sv
